/* design/cssf_pkg.sv */
// ----------------------------------------------------------------------------
// Coulomb stick/slip friction package
// Shared types, register codes and fixed-point helpers for the friction block.
// ----------------------------------------------------------------------------
package cssf_pkg;

    localparam int CSSF_FRAC_BITS = 16;
    localparam int UNIT_BITS      = 30;
    localparam int COEFF_BITS     = 12;
    localparam int ROOT_W         = 32;
    localparam int QUO_W          = 31;

    typedef logic [61:0] t_mag;
    localparam t_mag MAG_CAP = '1;

    typedef enum logic [2:0] {
        CFG_ENABLE      = 3'd0,
        CFG_VEL_CONTACT = 3'd1,
        CFG_FRIC_MODE   = 3'd2,
        CFG_INV_STEP    = 3'd3,
        CFG_STATIC      = 3'd4,
        CFG_KINETIC     = 3'd5,
        CFG_BELT_X      = 3'd6,
        CFG_BELT_Z      = 3'd7
    } t_cfg_idx;

    typedef enum logic [1:0] {
        FM_NONE       = 2'd0,
        FM_STICK_SLIP = 2'd1,
        FM_STICK      = 2'd2,
        FM_STICK_FLAG = 2'd3
    } t_fmode;

    typedef enum logic [1:0] {
        FS_ZERO  = 2'd0,
        FS_KILL  = 2'd1,
        FS_CLAMP = 2'd2
    } t_fsel;

    typedef struct packed {
        logic        enable;
        logic        vel_contact;
        t_fmode      mode;
        logic [31:0] inv;
        logic [15:0] sc;
        logic [15:0] kc;
        logic [31:0] belt_x;
        logic [31:0] belt_z;
    } t_cfg;

    typedef struct packed {
        logic            stuck;
        logic            neg_x;
        logic            neg_z;
        logic            dv_neg;
        logic            slow;
        logic [30:0]     mass;
        logic [31:0]     ax;
        logic [31:0]     az;
        logic [32:0]     adv;
        logic [32:0]     ady;
        logic [63:0]     sq;
        logic [3:0][63:0] pp_lo;
        logic [3:0][63:0] pp_hi;
        t_mag            mdv;
        t_mag            mdy;
        t_mag            mx;
        t_mag            mz;
        t_mag            nvel;
        t_mag            npos;
        t_mag            kx;
        t_mag            kz;
        t_mag            mkill;
        t_mag            kill;
        t_mag            lim_s;
        t_mag            lim_k;
        t_mag            lim_sel;
        t_mag            lim_c;
        logic [33:0]     sq_rem;
        logic [31:0]     root;
        logic [31:0]     dx_rem;
        logic [31:0]     dz_rem;
        logic [30:0]     qx;
        logic [30:0]     qz;
        t_fsel           fsel;
        logic [31:0]     fy;
        logic [31:0]     fx;
        logic [31:0]     fz;
    } t_item;

    function automatic logic [31:0] f_sat32(input logic [32:0] v);
        if (v[32] != v[31]) begin
            return v[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        return v[31:0];
    endfunction

    function automatic logic [32:0] f_abs33(input logic [32:0] v);
        return v[32] ? 33'(33'd0 - v) : v;
    endfunction

    function automatic t_mag f_mul_comb(input logic [63:0] hi, input logic [63:0] lo,
                                        input int sh);
        logic [96:0] full;
        logic [96:0] shd;
        full = {1'b0, hi, 32'b0} + {33'b0, lo};
        shd  = full >> sh;
        if (shd > 97'(MAG_CAP)) begin
            return MAG_CAP;
        end
        return shd[61:0];
    endfunction

    function automatic logic [31:0] f_signed_sat(input t_mag m, input logic neg);
        if (neg) begin
            if (m >= 62'h8000_0000) begin
                return 32'h8000_0000;
            end
            return 32'(32'd0 - m[31:0]);
        end
        if (m > 62'h7FFF_FFFF) begin
            return 32'h7FFF_FFFF;
        end
        return m[31:0];
    endfunction

endpackage

/* design/coulomb_stick_slip_friction.sv */
// ----------------------------------------------------------------------------
// Coulomb stick/slip friction
// Per contact vertex friction and normal force in signed fixed point.
// ----------------------------------------------------------------------------
// The block takes one vertex beat per cycle while the output is not held and
// returns one result beat for each, after the 32-stage pipelined square root
// of the squared speed and the 31-stage pipelined dividers that form the unit
// vector. When the output is held, the whole pipeline holds and input ready
// falls. Configuration writes are taken in every cycle.
module coulomb_stick_slip_friction import cssf_pkg::*; #(
    parameter int FRAC_BITS = CSSF_FRAC_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic signed [31:0] i_vel_x,
    input  logic signed [31:0] i_vel_y,
    input  logic signed [31:0] i_vel_z,
    input  logic        [30:0] i_mass,
    input  logic signed [31:0] i_target_vel_y,
    input  logic signed [31:0] i_target_pos_y,
    input  logic signed [31:0] i_free_pos_y,
    input  logic               i_stuck_in,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [31:0] o_force_add_y,
    output logic signed [31:0] o_friction_x,
    output logic signed [31:0] o_friction_z,
    output logic               o_stuck_out,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic        [2:0]  i_cfg_index,
    input  logic        [31:0] i_cfg_data
);

    localparam int K_SQ0 = 3;
    localparam int K_SQN = K_SQ0 + ROOT_W - 1;
    localparam int K_KM  = K_SQN + 1;
    localparam int K_DV0 = K_KM + 1;
    localparam int K_DVN = K_DV0 + QUO_W - 1;
    localparam int K_DEC = K_DVN + 1;
    localparam int K_OUT = K_DEC + 1;
    localparam int NSTG  = K_OUT + 1;

    localparam longint SPEED_EPS = ((64'd1 << FRAC_BITS) + 64'd999999) / 64'd1000000;
    localparam logic [63:0] EPS_SQ = 64'(SPEED_EPS * SPEED_EPS);
    localparam logic [31:0] INV_RESET = 32'(64'd100 << FRAC_BITS);

    t_cfg               r_cfg;
    t_item              r_pipe [NSTG];
    t_item              n_pipe [NSTG];
    logic [NSTG-1:0]    r_vld;
    logic               adv;
    logic [32:0]        w_dx;
    logic [32:0]        w_dz;
    logic [32:0]        w_dv;
    logic [32:0]        w_dy;
    logic [31:0]        w_rx;
    logic [31:0]        w_rz;

    function automatic t_item f_stage(input int k, input t_item x, input t_cfg c);
        t_item       y;
        logic [35:0] sq_t;
        logic [33:0] trial;
        logic [32:0] dx_t;
        logic [32:0] dz_t;
        logic [30:0] ux;
        logic [30:0] uz;
        logic        flag;
        int          i;
        int          j;
        y = x;
        i = ROOT_W - 1 - (k - K_SQ0);
        j = QUO_W - 1 - (k - K_DV0);
        if (k == 1) begin
            y.pp_lo[0] = 64'(x.ax) * 64'(x.ax);
            y.pp_lo[1] = 64'(x.az) * 64'(x.az);
            y.pp_lo[2] = 64'(x.mass) * 64'(x.adv);
            y.pp_lo[3] = 64'(x.mass) * 64'(x.ady);
            y.pp_hi[0] = 64'(x.mass) * 64'(x.ax);
            y.pp_hi[1] = 64'(x.mass) * 64'(x.az);
        end
        if (k == 2) begin
            y.sq     = x.pp_lo[0] + x.pp_lo[1];
            y.slow   = (y.sq < EPS_SQ);
            y.mdv    = t_mag'(x.pp_lo[2] >> FRAC_BITS);
            y.mdy    = t_mag'(x.pp_lo[3] >> FRAC_BITS);
            y.mx     = t_mag'(x.pp_hi[0] >> FRAC_BITS);
            y.mz     = t_mag'(x.pp_hi[1] >> FRAC_BITS);
            y.sq_rem = '0;
            y.root   = '0;
        end
        if (k >= K_SQ0 && k <= K_SQN) begin
            sq_t  = {x.sq_rem, x.sq[2*i +: 2]};
            trial = {x.root, 2'b01};
            if (sq_t >= 36'(trial)) begin
                y.sq_rem = 34'(sq_t - 36'(trial));
                y.root   = {x.root[30:0], 1'b1};
            end else begin
                y.sq_rem = sq_t[33:0];
                y.root   = {x.root[30:0], 1'b0};
            end
        end
        if (k == 3) begin
            y.pp_lo[0] = 64'(x.mdv[31:0]) * 64'(c.inv);
            y.pp_hi[0] = 64'(x.mdv[61:32]) * 64'(c.inv);
            y.pp_lo[1] = 64'(x.mdy[31:0]) * 64'(c.inv);
            y.pp_hi[1] = 64'(x.mdy[61:32]) * 64'(c.inv);
            y.pp_lo[2] = 64'(x.mx[31:0]) * 64'(c.inv);
            y.pp_hi[2] = 64'(x.mx[61:32]) * 64'(c.inv);
            y.pp_lo[3] = 64'(x.mz[31:0]) * 64'(c.inv);
            y.pp_hi[3] = 64'(x.mz[61:32]) * 64'(c.inv);
        end
        if (k == 4) begin
            y.nvel = f_mul_comb(x.pp_hi[0], x.pp_lo[0], FRAC_BITS);
            y.npos = f_mul_comb(x.pp_hi[1], x.pp_lo[1], FRAC_BITS);
            y.kx   = f_mul_comb(x.pp_hi[2], x.pp_lo[2], FRAC_BITS);
            y.kz   = f_mul_comb(x.pp_hi[3], x.pp_lo[3], FRAC_BITS);
        end
        if (k == 5) begin
            y.pp_lo[1] = 64'(x.npos[31:0]) * 64'(c.inv);
            y.pp_hi[1] = 64'(x.npos[61:32]) * 64'(c.inv);
        end
        if (k == 6) begin
            y.npos = f_mul_comb(x.pp_hi[1], x.pp_lo[1], FRAC_BITS);
        end
        if (k == 7) begin
            y.pp_lo[0] = 64'(c.sc) * 64'(x.npos[31:0]);
            y.pp_hi[0] = 64'(c.sc) * 64'(x.npos[61:32]);
            y.pp_lo[1] = 64'(c.kc) * 64'(x.npos[31:0]);
            y.pp_hi[1] = 64'(c.kc) * 64'(x.npos[61:32]);
            if (c.vel_contact) begin
                y.pp_lo[2] = 64'(c.sc) * 64'(x.nvel[31:0]);
                y.pp_hi[2] = 64'(c.sc) * 64'(x.nvel[61:32]);
            end else begin
                y.pp_lo[2] = 64'(c.sc) * 64'(x.npos[31:0]);
                y.pp_hi[2] = 64'(c.sc) * 64'(x.npos[61:32]);
            end
        end
        if (k == 8) begin
            y.lim_s   = f_mul_comb(x.pp_hi[0], x.pp_lo[0], COEFF_BITS);
            y.lim_k   = f_mul_comb(x.pp_hi[1], x.pp_lo[1], COEFF_BITS);
            y.lim_sel = f_mul_comb(x.pp_hi[2], x.pp_lo[2], COEFF_BITS);
        end
        if (k == K_KM) begin
            y.pp_lo[0] = 64'(x.mass) * 64'(x.root);
            y.dx_rem   = 32'(x.ax >> 1);
            y.dz_rem   = 32'(x.az >> 1);
            y.qx       = '0;
            y.qz       = '0;
        end
        if (k == K_DV0) begin
            y.mkill = t_mag'(x.pp_lo[0] >> FRAC_BITS);
        end
        if (k == K_DV0 + 1) begin
            y.pp_lo[0] = 64'(x.mkill[31:0]) * 64'(c.inv);
            y.pp_hi[0] = 64'(x.mkill[61:32]) * 64'(c.inv);
        end
        if (k == K_DV0 + 2) begin
            y.kill = f_mul_comb(x.pp_hi[0], x.pp_lo[0], FRAC_BITS);
        end
        if (k >= K_DV0 && k <= K_DVN) begin
            dx_t = {x.dx_rem, (j == QUO_W - 1) ? x.ax[0] : 1'b0};
            dz_t = {x.dz_rem, (j == QUO_W - 1) ? x.az[0] : 1'b0};
            if (dx_t >= 33'(x.root)) begin
                y.dx_rem = 32'(dx_t - 33'(x.root));
                y.qx[j]  = 1'b1;
            end else begin
                y.dx_rem = dx_t[31:0];
            end
            if (dz_t >= 33'(x.root)) begin
                y.dz_rem = 32'(dz_t - 33'(x.root));
                y.qz[j]  = 1'b1;
            end else begin
                y.dz_rem = dz_t[31:0];
            end
        end
        if (k == K_DEC) begin
            ux      = (x.root != '0) ? x.qx : '0;
            uz      = (x.root != '0) ? x.qz : '0;
            y.fsel  = FS_ZERO;
            y.lim_c = x.lim_sel;
            flag    = 1'b0;
            if (c.enable) begin
                case (c.mode) inside
                    FM_STICK_SLIP: begin
                        if ((x.stuck || x.slow) && !(x.kill > x.lim_s)) begin
                            y.stuck = 1'b1;
                            y.fsel  = FS_KILL;
                        end else if (x.lim_k >= x.kill) begin
                            y.stuck = 1'b1;
                            y.fsel  = FS_KILL;
                        end else begin
                            y.stuck = 1'b0;
                            y.fsel  = FS_CLAMP;
                            y.lim_c = x.lim_k;
                        end
                    end
                    FM_STICK, FM_STICK_FLAG: begin
                        if (x.kill > x.lim_sel) begin
                            if (!x.slow) begin
                                y.fsel = FS_CLAMP;
                                flag   = 1'b1;
                            end
                        end else begin
                            y.fsel = FS_KILL;
                        end
                        if (c.mode == FM_STICK_FLAG) begin
                            y.stuck = flag;
                        end
                    end
                    default: begin
                        y.fsel = FS_ZERO;
                    end
                endcase
            end
            y.pp_lo[0] = 64'(y.lim_c[31:0]) * 64'(ux);
            y.pp_hi[0] = 64'(y.lim_c[61:32]) * 64'(ux);
            y.pp_lo[1] = 64'(y.lim_c[31:0]) * 64'(uz);
            y.pp_hi[1] = 64'(y.lim_c[61:32]) * 64'(uz);
            y.fy = (c.enable && c.vel_contact) ? f_signed_sat(x.nvel, x.dv_neg) : '0;
        end
        if (k == K_OUT) begin
            case (x.fsel)
                FS_KILL: begin
                    y.fx = f_signed_sat(x.kx, x.neg_x);
                    y.fz = f_signed_sat(x.kz, x.neg_z);
                end
                FS_CLAMP: begin
                    y.fx = f_signed_sat(f_mul_comb(x.pp_hi[0], x.pp_lo[0], UNIT_BITS), x.neg_x);
                    y.fz = f_signed_sat(f_mul_comb(x.pp_hi[1], x.pp_lo[1], UNIT_BITS), x.neg_z);
                end
                default: begin
                    y.fx = '0;
                    y.fz = '0;
                end
            endcase
        end
        return y;
    endfunction

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enable      <= 1'b0;
            r_cfg.vel_contact <= 1'b0;
            r_cfg.mode        <= FM_NONE;
            r_cfg.inv         <= INV_RESET;
            r_cfg.sc          <= '0;
            r_cfg.kc          <= '0;
            r_cfg.belt_x      <= '0;
            r_cfg.belt_z      <= '0;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_ENABLE:      r_cfg.enable      <= i_cfg_data[0];
                CFG_VEL_CONTACT: r_cfg.vel_contact <= i_cfg_data[0];
                CFG_FRIC_MODE:   r_cfg.mode        <= t_fmode'(i_cfg_data[1:0]);
                CFG_INV_STEP:    r_cfg.inv         <= i_cfg_data;
                CFG_STATIC:      r_cfg.sc          <= i_cfg_data[15:0];
                CFG_KINETIC:     r_cfg.kc          <= i_cfg_data[15:0];
                CFG_BELT_X:      r_cfg.belt_x      <= i_cfg_data;
                CFG_BELT_Z:      r_cfg.belt_z      <= i_cfg_data;
            endcase
        end
    end

    assign w_dx = {i_vel_x[31], i_vel_x} - {r_cfg.belt_x[31], r_cfg.belt_x};
    assign w_dz = {i_vel_z[31], i_vel_z} - {r_cfg.belt_z[31], r_cfg.belt_z};
    assign w_dv = {i_target_vel_y[31], i_target_vel_y} - {i_vel_y[31], i_vel_y};
    assign w_dy = {i_target_pos_y[31], i_target_pos_y} - {i_free_pos_y[31], i_free_pos_y};
    assign w_rx = f_sat32(w_dx);
    assign w_rz = f_sat32(w_dz);

    always_comb begin
        n_pipe[0]        = '0;
        n_pipe[0].stuck  = i_stuck_in;
        n_pipe[0].mass   = i_mass;
        n_pipe[0].ax     = w_rx[31] ? 32'(32'd0 - w_rx) : w_rx;
        n_pipe[0].az     = w_rz[31] ? 32'(32'd0 - w_rz) : w_rz;
        n_pipe[0].neg_x  = !w_rx[31] && (w_rx != '0);
        n_pipe[0].neg_z  = !w_rz[31] && (w_rz != '0);
        n_pipe[0].adv    = f_abs33(w_dv);
        n_pipe[0].ady    = f_abs33(w_dy);
        n_pipe[0].dv_neg = w_dv[32];
    end

    for (genvar g = 1; g < NSTG; g++) begin : g_stage
        always_comb begin
            n_pipe[g] = f_stage(g, r_pipe[g-1], r_cfg);
        end
    end

    assign adv        = !r_vld[NSTG-1] || i_out_ready;
    assign o_in_ready = adv;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_pipe <= n_pipe;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[NSTG-2:0], i_in_valid};
        end
    end

    assign o_out_valid   = r_vld[NSTG-1];
    assign o_force_add_y = r_pipe[NSTG-1].fy;
    assign o_friction_x  = r_pipe[NSTG-1].fx;
    assign o_friction_z  = r_pipe[NSTG-1].fz;
    assign o_stuck_out   = r_pipe[NSTG-1].stuck;

endmodule

/* design/cssf_chk.sv */
// ----------------------------------------------------------------------------
// Coulomb stick/slip friction port checker
// Watches the top-level ports for handshake, stall and reset behaviour.
// ----------------------------------------------------------------------------
module cssf_chk (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input logic signed [31:0] i_vel_x,
    input logic signed [31:0] i_vel_y,
    input logic signed [31:0] i_vel_z,
    input logic        [30:0] i_mass,
    input logic signed [31:0] i_target_vel_y,
    input logic signed [31:0] i_target_pos_y,
    input logic signed [31:0] i_free_pos_y,
    input logic               i_stuck_in,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input logic signed [31:0] o_force_add_y,
    input logic signed [31:0] o_friction_x,
    input logic signed [31:0] o_friction_z,
    input logic               o_stuck_out,
    input logic               i_cfg_valid,
    input logic               o_cfg_ready,
    input logic        [2:0]  i_cfg_index,
    input logic        [31:0] i_cfg_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result beat dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_friction_x) && $stable(o_friction_z)
            && $stable(o_force_add_y) && $stable(o_stuck_out))
        else $error("result beat changed while stalled");

    a_stall_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |-> !o_in_ready)
        else $error("input taken while the pipeline is held");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result beat shown straight after reset");

endmodule

bind coulomb_stick_slip_friction cssf_chk u_cssf_chk (.*);

/* bench/tb_coulomb_stick_slip_friction.sv */
// ----------------------------------------------------------------------------
// Coulomb stick/slip friction testbench
// Drives vertex beats through the friction block under random flow control and
// compares every result beat with a fixed-point prediction of the forces and
// stick flag. A run with the reset configuration comes first, then directed
// corner cases, then random configurations.
module tb_coulomb_stick_slip_friction;
    import cssf_pkg::*;

    localparam logic [63:0] FORCE_CAP = 64'h3FFF_FFFF_FFFF_FFFF;
    localparam int          FB        = CSSF_FRAC_BITS;
    localparam logic [63:0] SLOW_EPS  = ((64'd1 << FB) + 64'd999999) / 64'd1000000;

    typedef struct {
        logic [31:0] vx;
        logic [31:0] vy;
        logic [31:0] vz;
        logic [30:0] mass;
        logic [31:0] tvy;
        logic [31:0] tpy;
        logic [31:0] fpy;
        logic        stuck;
    } t_vertex;

    typedef struct {
        logic [31:0] fy;
        logic [31:0] fx;
        logic [31:0] fz;
        logic        stuck;
    } t_force;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [31:0] i_vel_x = '0;
    logic [31:0] i_vel_y = '0;
    logic [31:0] i_vel_z = '0;
    logic [30:0] i_mass = '0;
    logic [31:0] i_target_vel_y = '0;
    logic [31:0] i_target_pos_y = '0;
    logic [31:0] i_free_pos_y = '0;
    logic        i_stuck_in = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [31:0] o_force_add_y;
    logic [31:0] o_friction_x;
    logic [31:0] o_friction_z;
    logic        o_stuck_out;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;

    coulomb_stick_slip_friction dut (.*);

    // Shadow copy of the configuration registers.
    logic        cf_enable = 1'b0;
    logic        cf_vel_contact = 1'b0;
    t_fmode      cf_mode = FM_NONE;
    logic [31:0] cf_inv = 32'd100 << FB;
    logic [15:0] cf_sc = '0;
    logic [15:0] cf_kc = '0;
    logic [31:0] cf_belt_x = '0;
    logic [31:0] cf_belt_z = '0;

    t_force expected_forces[$];
    int     n_errors = 0;
    int     n_vertices = 0;
    int     n_results = 0;
    int     hold_req = 0;
    int     hold_left = 0;
    bit     rx_gappy = 1'b0;
    bit     tx_gappy = 1'b0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    initial begin
        #(8 * 2000000);
        $display("Simulation FAILED");
        $finish;
    end

    function automatic logic [63:0] mul_trunc(input logic [63:0] a, input logic [63:0] b,
                                              input int sh);
        logic [127:0] p;
        p = ({64'b0, a} * {64'b0, b}) >> sh;
        if (p > {64'b0, FORCE_CAP}) begin
            return FORCE_CAP;
        end
        return p[63:0];
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic longint clamp_word(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic logic [31:0] signed_word(input logic [63:0] m, input bit neg);
        longint s;
        s = neg ? -longint'(m) : longint'(m);
        return 32'(clamp_word(s));
    endfunction

    function automatic t_force predict_friction(input t_vertex v);
        t_force      r;
        longint      rx, rz, dv, dy;
        logic [63:0] ax, az, sq, vn, ux, uz, adv, ady, nvel, npos, nsel;
        logic [63:0] kx, kz, kill, lim;
        bit          slow, stk;
        r.fy = '0;
        r.fx = '0;
        r.fz = '0;
        r.stuck = v.stuck;
        if (!cf_enable) begin
            return r;
        end
        rx = clamp_word(longint'($signed(v.vx)) - longint'($signed(cf_belt_x)));
        rz = clamp_word(longint'($signed(v.vz)) - longint'($signed(cf_belt_z)));
        ax = rx < 0 ? -rx : rx;
        az = rz < 0 ? -rz : rz;
        sq = ax * ax + az * az;
        slow = sq < SLOW_EPS * SLOW_EPS;
        vn = int_sqrt(sq);
        ux = vn != 0 ? (ax << UNIT_BITS) / vn : 0;
        uz = vn != 0 ? (az << UNIT_BITS) / vn : 0;
        dv = longint'($signed(v.tvy)) - longint'($signed(v.vy));
        dy = longint'($signed(v.tpy)) - longint'($signed(v.fpy));
        adv = dv < 0 ? -dv : dv;
        ady = dy < 0 ? -dy : dy;
        nvel = mul_trunc(mul_trunc(64'(v.mass), adv, FB), 64'(cf_inv), FB);
        npos = mul_trunc(mul_trunc(mul_trunc(64'(v.mass), ady, FB), 64'(cf_inv), FB),
                         64'(cf_inv), FB);
        if (cf_vel_contact) begin
            r.fy = signed_word(nvel, dv < 0);
            nsel = nvel;
        end else begin
            nsel = npos;
        end
        kx = mul_trunc(mul_trunc(64'(v.mass), ax, FB), 64'(cf_inv), FB);
        kz = mul_trunc(mul_trunc(64'(v.mass), az, FB), 64'(cf_inv), FB);
        kill = mul_trunc(mul_trunc(64'(v.mass), vn, FB), 64'(cf_inv), FB);
        stk = v.stuck;
        if (cf_mode == FM_STICK_SLIP) begin
            if (stk || slow) begin
                lim = mul_trunc(64'(cf_sc), npos, COEFF_BITS);
                stk = 1'b1;
                r.fx = signed_word(kx, rx > 0);
                r.fz = signed_word(kz, rz > 0);
                if (kill > lim) stk = 1'b0;
            end
            if (!stk) begin
                lim = mul_trunc(64'(cf_kc), npos, COEFF_BITS);
                if (lim >= kill) begin
                    stk = 1'b1;
                    r.fx = signed_word(kx, rx > 0);
                    r.fz = signed_word(kz, rz > 0);
                end else begin
                    r.fx = signed_word(mul_trunc(lim, ux, UNIT_BITS), rx > 0);
                    r.fz = signed_word(mul_trunc(lim, uz, UNIT_BITS), rz > 0);
                end
            end
        end else if (cf_mode == FM_STICK || cf_mode == FM_STICK_FLAG) begin
            lim = mul_trunc(64'(cf_sc), nsel, COEFF_BITS);
            r.fx = signed_word(kx, rx > 0);
            r.fz = signed_word(kz, rz > 0);
            if (cf_mode == FM_STICK_FLAG) stk = 1'b0;
            if (kill > lim) begin
                if (!slow) begin
                    r.fx = signed_word(mul_trunc(lim, ux, UNIT_BITS), rx > 0);
                    r.fz = signed_word(mul_trunc(lim, uz, UNIT_BITS), rz > 0);
                    if (cf_mode == FM_STICK_FLAG) stk = 1'b1;
                end else begin
                    r.fx = '0;
                    r.fz = '0;
                end
            end
        end
        r.stuck = stk;
        return r;
    endfunction

    // Receiver side: random or steady ready, with occasional long holds.
    always @(negedge i_clk) begin
        if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req = 0;
        end
        if (hold_left > 0) begin
            i_out_ready <= 1'b0;
            hold_left = hold_left - 1;
        end else if (rx_gappy) begin
            if ($urandom_range(0, 199) == 0) hold_left = $urandom_range(20, 60);
            i_out_ready <= $urandom_range(0, 9) < 7;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    function automatic bit field_ok(input string name, input logic [31:0] exp_v,
                                    input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, act_v);
            return 1'b0;
        end
        return 1'b1;
    endfunction

    always @(posedge i_clk) begin
        t_force e;
        bit     ok;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            n_results++;
            if (expected_forces.size() == 0) begin
                $display("%0t: unexpected result beat, got %h %h %h %b", $time,
                         o_force_add_y, o_friction_x, o_friction_z, o_stuck_out);
                n_errors++;
            end else begin
                e = expected_forces.pop_front();
                ok = field_ok("force_add_y", e.fy, o_force_add_y);
                ok = field_ok("friction_x", e.fx, o_friction_x) && ok;
                ok = field_ok("friction_z", e.fz, o_friction_z) && ok;
                ok = field_ok("stuck_out", 32'(e.stuck), 32'(o_stuck_out)) && ok;
                if (!ok) n_errors++;
            end
        end
    end

    task automatic cfg_write(input t_cfg_idx idx, input logic [31:0] d);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = d;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_ENABLE:      cf_enable = d[0];
            CFG_VEL_CONTACT: cf_vel_contact = d[0];
            CFG_FRIC_MODE:   cf_mode = t_fmode'(d[1:0]);
            CFG_INV_STEP:    cf_inv = d;
            CFG_STATIC:      cf_sc = d[15:0];
            CFG_KINETIC:     cf_kc = d[15:0];
            CFG_BELT_X:      cf_belt_x = d;
            CFG_BELT_Z:      cf_belt_z = d;
            default:         ;
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic set_all(input bit en, input bit vc, input t_fmode md,
                           input logic [31:0] inv, input logic [15:0] sc,
                           input logic [15:0] kc, input logic [31:0] bx,
                           input logic [31:0] bz);
        cfg_write(CFG_ENABLE, 32'(en));
        cfg_write(CFG_VEL_CONTACT, 32'(vc));
        cfg_write(CFG_FRIC_MODE, 32'(md));
        cfg_write(CFG_INV_STEP, inv);
        cfg_write(CFG_STATIC, 32'(sc));
        cfg_write(CFG_KINETIC, 32'(kc));
        cfg_write(CFG_BELT_X, bx);
        cfg_write(CFG_BELT_Z, bz);
    endtask

    task automatic wait_drained();
        while (expected_forces.size() != 0) @(negedge i_clk);
        repeat (100) @(negedge i_clk);
    endtask

    // Called at a falling edge; returns at a falling edge after the beat.
    task automatic send_vertex(input t_vertex v);
        int gap;
        i_in_valid = 1'b1;
        i_vel_x = v.vx;
        i_vel_y = v.vy;
        i_vel_z = v.vz;
        i_mass = v.mass;
        i_target_vel_y = v.tvy;
        i_target_pos_y = v.tpy;
        i_free_pos_y = v.fpy;
        i_stuck_in = v.stuck;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        expected_forces.push_back(predict_friction(v));
        n_vertices++;
        @(negedge i_clk);
        i_in_valid = 1'b0;
        gap = 0;
        if (tx_gappy) begin
            gap = $urandom_range(0, 99);
            gap = gap < 55 ? 0 : (gap < 90 ? $urandom_range(1, 3) : $urandom_range(10, 40));
        end
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 6))
            0, 1: return $urandom();
            2:    return 32'($signed($urandom_range(0, 2097152)) - 1048576);
            3:    return 32'($signed($urandom_range(0, 8)) - 4);
            4:    return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            5:    return 32'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
            default: return '0;
        endcase
    endfunction

    function automatic t_vertex rand_vertex();
        t_vertex v;
        v.vx = rand_word();
        v.vy = rand_word();
        v.vz = rand_word();
        v.tvy = rand_word();
        v.tpy = rand_word();
        v.fpy = rand_word();
        v.stuck = ($urandom_range(0, 1) == 1);
        case ($urandom_range(0, 5))
            0:       v.mass = 31'($urandom());
            1:       v.mass = '1;
            2:       v.mass = '0;
            default: v.mass = 31'($urandom_range(0, 1 << 18));
        endcase
        if ($urandom_range(0, 7) == 0) begin
            v.vx = cf_belt_x + 32'($signed($urandom_range(0, 2)) - 1);
            v.vz = cf_belt_z + 32'($signed($urandom_range(0, 2)) - 1);
        end
        return v;
    endfunction

    function automatic t_vertex mk(input logic [31:0] vx, input logic [31:0] vy,
                                   input logic [31:0] vz, input logic [30:0] m,
                                   input logic [31:0] tvy, input logic [31:0] tpy,
                                   input logic [31:0] fpy, input logic st);
        t_vertex v;
        v.vx = vx;
        v.vy = vy;
        v.vz = vz;
        v.mass = m;
        v.tvy = tvy;
        v.tpy = tpy;
        v.fpy = fpy;
        v.stuck = st;
        return v;
    endfunction

    task automatic test_reset_state();
        repeat (8) send_vertex(rand_vertex());
        wait_drained();
    endtask

    task automatic test_directed();
        set_all(1'b1, 1'b0, FM_STICK_SLIP, 32'd100 << FB, 16'h1000, 16'h0800, '0, '0);
        send_vertex(mk('0, '0, '0, 31'h10000, '0, 32'h100, '0, 1'b0));
        send_vertex(mk(32'h100, '0, 32'h80, 31'h10000, '0, 32'h10000, '0, 1'b1));
        send_vertex(mk(32'h50000, '0, 32'hFFFB0000, 31'h10000, '0, 32'h100, '0, 1'b1));
        send_vertex(mk(32'h20000, '0, '0, 31'h10000, '0, 32'h40000, '0, 1'b0));
        send_vertex(mk(32'h20000, '0, 32'h1, '0, '0, 32'h100, '0, 1'b1));
        wait_drained();
        set_all(1'b1, 1'b1, FM_STICK, 32'd50 << FB, 16'h2000, 16'h0, '0, '0);
        send_vertex(mk(32'h30000, 32'h10000, 32'h10000, 31'h20000, 32'h30000, '0, '0, 1'b1));
        send_vertex(mk(32'hFFFD0000, 32'h30000, '0, 31'h20000, 32'h10000, '0, '0, 1'b0));
        send_vertex(mk(32'h1, 32'h8000_0000, '0, 31'h20000, 32'h7FFF_FFFF, '0, '0, 1'b1));
        send_vertex(mk('0, 32'h7FFF_FFFF, '0, 31'h20000, 32'h8000_0000, '0, '0, 1'b0));
        wait_drained();
        set_all(1'b1, 1'b0, FM_STICK_FLAG, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF,
                32'h8000_0000, 32'h7FFF_FFFF);
        send_vertex(mk(32'h7FFF_FFFF, '0, 32'h8000_0000, '1, '0, 32'h7FFF_FFFF,
                       32'h8000_0000, 1'b0));
        send_vertex(mk(32'h8000_0000, '0, 32'h7FFF_FFFF, '1, '0, 32'h1, '0, 1'b1));
        send_vertex(mk('0, '0, '0, 31'h100, '0, '0, '0, 1'b0));
        wait_drained();
        set_all(1'b1, 1'b0, FM_STICK_FLAG, 32'd100 << FB, 16'h0100, 16'h0, '0, '0);
        send_vertex(mk(32'h80000, '0, 32'h40000, 31'h10000, '0, 32'h10, '0, 1'b0));
        send_vertex(mk('0, '0, '0, 31'h10000, '0, '0, '0, 1'b1));
        wait_drained();
        set_all(1'b1, 1'b1, FM_NONE, '0, 16'h1000, 16'h1000, 32'h10000, '0);
        send_vertex(mk(32'h30000, '0, 32'h1000, 31'h10000, 32'h1000, '0, '0, 1'b1));
        wait_drained();
        cfg_write(CFG_INV_STEP, 32'd100 << FB);
        send_vertex(mk(32'h30000, '0, 32'h1000, 31'h10000, 32'hFFFF0000, '0, '0, 1'b0));
        wait_drained();
        cfg_write(CFG_ENABLE, 32'd0);
        send_vertex(mk(32'h30000, '0, 32'h1000, 31'h10000, 32'h1000, '0, '0, 1'b1));
        send_vertex(mk(32'h30000, '0, 32'h1000, 31'h10000, 32'h1000, '0, '0, 1'b0));
        wait_drained();
    endtask

    task automatic random_config();
        logic [31:0] inv;
        logic [15:0] sc, kc;
        case ($urandom_range(0, 4))
            0:       inv = '0;
            1:       inv = '1;
            2:       inv = $urandom();
            default: inv = 32'($urandom_range(1, 400)) << FB;
        endcase
        sc = $urandom_range(0, 3) == 0 ? ($urandom_range(0, 1) ? 16'hFFFF : 16'h0)
                                       : 16'($urandom());
        kc = $urandom_range(0, 3) == 0 ? ($urandom_range(0, 1) ? 16'hFFFF : 16'h0)
                                       : 16'($urandom());
        set_all($urandom_range(0, 7) != 0, $urandom_range(0, 1) == 1,
                t_fmode'(2'($urandom_range(0, 3))), inv, sc, kc, rand_word(), rand_word());
    endtask

    task automatic test_random_phases();
        for (int ph = 0; ph < 12; ph++) begin
            random_config();
            tx_gappy = ph % 3 != 0;
            rx_gappy = ph % 4 != 1;
            repeat (100) send_vertex(rand_vertex());
            wait_drained();
        end
    endtask

    task automatic test_backpressure();
        tx_gappy = 1'b0;
        rx_gappy = 1'b1;
        random_config();
        hold_req = 300;
        repeat (150) send_vertex(rand_vertex());
        wait_drained();
    endtask

    task automatic test_sender_pause();
        tx_gappy = 1'b1;
        cfg_write(CFG_ENABLE, 32'd1);
        repeat (25) send_vertex(rand_vertex());
        i_in_valid = 1'b0;
        while (expected_forces.size() != 0) @(negedge i_clk);
        repeat (25) send_vertex(rand_vertex());
        wait_drained();
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_reset_state();
        test_directed();
        test_random_phases();
        test_backpressure();
        test_sender_pause();
        $display("Sent %0d vertex beats and checked %0d result beats across all friction",
                 n_vertices, n_results);
        $display("modes, both contact types, extreme settings and flow-control stalls.");
        if (n_errors == 0 && expected_forces.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
